>>> sv/nsr_pkg.sv
// Package for the Newton square root unit.
// Holds the fixed-point widths, the iteration limit and the controller/datapath structs.
// No dependencies.
`default_nettype none

package nsr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_ITER  = 64;

    localparam int VALUE_W = 32;
    localparam int TOL_W   = 32;
    localparam int ROOT_W  = 25;

    // Guesses, quotients and the numerator share this width.
    localparam int XW     = VALUE_W + FRAC_BITS;
    localparam int BIT_W  = $clog2(XW);
    localparam int ITER_W = $clog2(MAX_ITER);

    localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(2);
    localparam logic [XW-1:0]     ROOT_MAX  = XW'((64'd1 << ROOT_W) - 64'd1);

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic add;
        logic advance;
        logic emit;
        logic cap;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic conv;
    } t_sts;

endpackage

`default_nettype wire

>>> sv/nsr_intf.sv
// Valid/ready channel interfaces of the Newton square root unit.
// Depends on nsr_pkg for the field widths.
`default_nettype none

interface nsr_in_if;
    logic                          valid;
    logic                          ready;
    logic [nsr_pkg::VALUE_W-1:0]   value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface nsr_out_if;
    logic                          valid;
    logic                          ready;
    logic [nsr_pkg::ROOT_W-1:0]    root;
    logic                          cap_reached;
    modport source (output valid, output root, output cap_reached, input ready);
    modport sink   (input valid, input root, input cap_reached, output ready);
endinterface

interface nsr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [nsr_pkg::TOL_W-1:0]     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/nsr_datapath.sv
// Datapath of the Newton square root unit: guess registers, shift-subtract divider,
// convergence test, tolerance register and the output register. Depends on nsr_pkg.
`default_nettype none

module nsr_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire nsr_pkg::t_cmd                 i_cmd,
    output      nsr_pkg::t_sts                 o_sts,
    input  wire logic [nsr_pkg::VALUE_W-1:0]   i_value,
    input  wire logic                          i_tol_we,
    input  wire logic [nsr_pkg::TOL_W-1:0]     i_tol,
    output      logic [nsr_pkg::ROOT_W-1:0]    o_root,
    output      logic                          o_cap
);

    logic [nsr_pkg::XW-1:0]     r_num;
    logic [nsr_pkg::XW-1:0]     r_x;
    logic [nsr_pkg::XW-1:0]     r_nx;
    logic [nsr_pkg::XW-1:0]     r_div;
    logic [nsr_pkg::XW-1:0]     r_quo;
    logic [nsr_pkg::XW-1:0]     r_rem;
    logic [nsr_pkg::TOL_W-1:0]  r_tol;
    logic [nsr_pkg::ROOT_W-1:0] r_root;
    logic                       r_cap;

    logic [nsr_pkg::XW-1:0]     div_src;
    logic [nsr_pkg::XW:0]       rem_sh;
    logic [nsr_pkg::XW:0]       rem_sub;
    logic                       q_bit;
    logic [nsr_pkg::XW:0]       sum;
    logic [nsr_pkg::XW-1:0]     diff;

    assign div_src = i_cmd.advance ? r_nx : r_x;
    assign rem_sh  = {r_rem, r_quo[nsr_pkg::XW-1]};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign q_bit   = ~rem_sub[nsr_pkg::XW];
    assign sum     = {1'b0, r_x} + {1'b0, r_quo};
    assign diff    = (r_nx >= r_x) ? (r_nx - r_x) : (r_x - r_nx);

    assign o_sts.zero = (r_x == '0);
    assign o_sts.conv = (diff < nsr_pkg::XW'(r_tol));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= nsr_pkg::TOL_RESET;
        end else if (i_tol_we) begin
            r_tol <= i_tol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= nsr_pkg::XW'(i_value);
            r_num <= nsr_pkg::XW'(i_value) << nsr_pkg::FRAC_BITS;
            r_nx  <= '0;
        end
        if (i_cmd.advance) begin
            r_x <= r_nx;
        end
        if (i_cmd.div_start || i_cmd.advance) begin
            r_div <= (div_src == '0) ? nsr_pkg::XW'(1) : div_src;
            r_quo <= r_num;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[nsr_pkg::XW-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[nsr_pkg::XW-1:0] : rem_sh[nsr_pkg::XW-1:0];
        end
        if (i_cmd.add) begin
            r_nx <= sum[nsr_pkg::XW:1];
        end
        if (i_cmd.emit) begin
            r_root <= (r_nx > nsr_pkg::ROOT_MAX) ? nsr_pkg::ROOT_MAX[nsr_pkg::ROOT_W-1:0]
                                                 : r_nx[nsr_pkg::ROOT_W-1:0];
            r_cap  <= i_cmd.cap;
        end
    end

    assign o_root = r_root;
    assign o_cap  = r_cap;

endmodule

`default_nettype wire

>>> sv/nsr_ctrl.sv
// Controller of the Newton square root unit: sequences the divider bits and the
// Newton steps, applies the iteration cap and owns the output valid flag. Depends on nsr_pkg.
`default_nettype none

module nsr_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_ready,
    output      logic           o_out_valid,
    input  wire logic           i_out_ready,
    input  wire nsr_pkg::t_sts  i_sts,
    output      nsr_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [nsr_pkg::BIT_W-1:0]  LAST_BIT  = nsr_pkg::BIT_W'(nsr_pkg::XW - 1);
    localparam logic [nsr_pkg::ITER_W-1:0] LAST_ITER = nsr_pkg::ITER_W'(nsr_pkg::MAX_ITER - 1);

    logic [2:0]                  r_state, n_state;
    logic [nsr_pkg::BIT_W-1:0]   r_bit, n_bit;
    logic [nsr_pkg::ITER_W-1:0]  r_iter, n_iter;
    logic                        r_cap, n_cap;
    logic                        r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_iter      = r_iter;
        n_cap       = r_cap;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.cap   = r_cap;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_iter = '0;
                if (i_sts.zero) begin
                    n_cap   = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_bit           = '0;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_bit          = r_bit + 1'b1;
                if (r_bit == LAST_BIT) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.conv) begin
                    n_cap   = 1'b0;
                    n_state = S_EMIT;
                end else if (r_iter == LAST_ITER) begin
                    n_cap   = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_iter        = r_iter + 1'b1;
                    n_bit         = '0;
                    n_state       = S_DIV;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_iter      <= '0;
            r_cap       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_iter      <= n_iter;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> sv/newton_square_root_unit.sv
// Newton square root unit: Q16.16 square root by Newton steps with a bit-serial divider.
// A zero item goes straight to the output; any other runs 1 to MAX_ITER Newton steps, and
// each step divides over all 48 quotient bits, then passes an add state and a check state.
// One item at a time; the next item is taken once the result sits in the output register.
// Synchronous active-low reset clears control state and sets the tolerance to 2.
// Depends on nsr_pkg, nsr_intf, nsr_ctrl and nsr_datapath.
`default_nettype none

module newton_square_root_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    nsr_in_if.sink     i_in,
    nsr_out_if.source  o_out,
    nsr_cfg_if.sink    i_cfg
);

    nsr_pkg::t_cmd w_cmd;
    nsr_pkg::t_sts w_sts;
    logic          in_ready;
    logic          out_valid;

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign i_cfg.ready = 1'b1;

    nsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    nsr_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_value  (i_in.value),
        .i_tol_we (i_cfg.valid),
        .i_tol    (i_cfg.data),
        .o_root   (o_out.root),
        .o_cap    (o_out.cap_reached)
    );

    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (i_in.valid && in_ready))
        else $error("load command without an accepted item");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.div_start, w_cmd.div_step, w_cmd.add,
                  w_cmd.advance, w_cmd.emit}))
        else $error("datapath commands overlap");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> out_valid)
        else $error("emitted item is not presented");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_sts.zero) |=> (o_out.root == '0 && !o_out.cap_reached))
        else $error("zero item gave a nonzero result");

endmodule

`default_nettype wire

>>> dv/newton_square_root_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for newton_square_root_unit: a table of directed items, then random items
// under several tolerance settings, each result checked against a Newton step predictor or a typed-in root.
// Depends on nsr_pkg, the channel interfaces in nsr_intf and the unit itself.

module newton_square_root_unit_tb;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 64;
    localparam int ROW_COUNT = 27;
    localparam int PHASE_COUNT = 7;

    typedef enum logic {
        ROW_ITEM,
        ROW_TOL
    } t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic [31:0]                word;
        logic                       typed;
        logic [nsr_pkg::ROOT_W-1:0] root;
        logic                       cap_reached;
    } t_stim_row;

    typedef struct packed {
        logic [nsr_pkg::ROOT_W-1:0] root;
        logic                       cap_reached;
    } t_root_result;

    logic i_clk;
    logic i_rst_n;

    nsr_in_if  in_if();
    nsr_out_if out_if();
    nsr_cfg_if cfg_if();

    newton_square_root_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_root_result  pending_roots[$];
    t_root_result  want_root;
    logic [31:0]   tol_setting;
    logic          steady;
    int            error_count;
    int            idle_cycles;
    t_stim_row     directed_rows [ROW_COUNT];

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic t_root_result predict_root(input logic [31:0] value,
                                                  input logic [31:0] tol);
        logic [63:0]  num;
        logic [63:0]  guess;
        logic [63:0]  next_guess;
        logic [63:0]  divisor;
        logic [63:0]  delta;
        logic         done;
        int           step;
        t_root_result res;
        res.root = '0;
        res.cap_reached = 1'b0;
        if (value == 32'd0) begin
            return res;
        end
        num = {32'd0, value} << nsr_pkg::FRAC_BITS;
        guess = {32'd0, value};
        next_guess = '0;
        done = 1'b0;
        for (step = 0; step < nsr_pkg::MAX_ITER && !done; step++) begin
            divisor = (guess == 64'd0) ? 64'd1 : guess;
            next_guess = (guess + num / divisor) >> 1;
            delta = (next_guess >= guess) ? next_guess - guess : guess - next_guess;
            if (delta < {32'd0, tol}) begin
                done = 1'b1;
            end else begin
                guess = next_guess;
            end
        end
        res.cap_reached = !done;
        res.root = (next_guess > 64'(nsr_pkg::ROOT_MAX)) ? '1
                                                         : next_guess[nsr_pkg::ROOT_W-1:0];
        return res;
    endfunction

    function automatic logic [31:0] draw_value();
        logic [31:0] k;
        k = $urandom_range(1, 255);
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 16));
            1: return 32'd1 << $urandom_range(0, 31);
            2: return (k * k) << nsr_pkg::FRAC_BITS;
            3: return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
            4: return 32'($urandom_range(1, 32'hFFFF));
            5: return 32'h0000_FFF0 + 32'($urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_roots.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_tolerance(input logic [31:0] tol);
        wait_idle();
        cfg_if.data  <= tol;
        cfg_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!(cfg_if.valid && cfg_if.ready)) begin
            @(posedge i_clk);
        end
        cfg_if.valid <= 1'b0;
        tol_setting = tol;
    endtask

    task automatic send_value(input logic [31:0] value, input logic typed,
                              input t_root_result typed_result);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.value <= value;
        in_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!(in_if.valid && in_if.ready)) begin
            @(posedge i_clk);
        end
        pending_roots.push_back(typed ? typed_result : predict_root(value, tol_setting));
    endtask

    initial begin
        int stall;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_if.valid && out_if.ready)) begin
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_roots.size() == 0) begin
                report_mismatch($sformatf("unexpected result root=%h cap=%b",
                                          out_if.root, out_if.cap_reached));
            end else begin
                want_root = pending_roots.pop_front();
                if (out_if.root !== want_root.root) begin
                    report_mismatch($sformatf("root %h, expected %h",
                                              out_if.root, want_root.root));
                end
                if (out_if.cap_reached !== want_root.cap_reached) begin
                    report_mismatch($sformatf("cap_reached %b, expected %b (root %h)",
                                              out_if.cap_reached, want_root.cap_reached,
                                              want_root.root));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [31:0]  phase_tols [PHASE_COUNT];
        int           phase_items [PHASE_COUNT];
        int           row_idx;
        int           phase_idx;
        int           item_idx;
        t_root_result typed_result;

        error_count = 0;
        idle_cycles = 0;
        steady = 1'b0;
        tol_setting = nsr_pkg::TOL_RESET;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.value <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;

        // Rows run first, from the reset tolerance on; roots that follow from one step or
        // from an exact first guess are typed in, the rest come from the predictor.
        directed_rows = '{
            '{ROW_ITEM, 32'h0000_0000, 1'b1, 25'h000_0000, 1'b0},
            '{ROW_ITEM, 32'h0001_0000, 1'b1, 25'h001_0000, 1'b0},
            '{ROW_ITEM, 32'h0000_0001, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'h4000_0000, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'h0000_0002, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'h0000_FFFF, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'h8000_0000, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'h0001_0001, 1'b0, 25'h0, 1'b0},
            '{ROW_TOL,  32'h0000_0001, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'h0000_0003, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'h1234_5678, 1'b0, 25'h0, 1'b0},
            '{ROW_TOL,  32'hFFFF_FFFF, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 25'h1FF_FFFF, 1'b0},
            '{ROW_ITEM, 32'h0000_0001, 1'b1, 25'h000_8000, 1'b0},
            '{ROW_ITEM, 32'h0000_0000, 1'b1, 25'h000_0000, 1'b0},
            '{ROW_ITEM, 32'h0002_0000, 1'b1, 25'h001_8000, 1'b0},
            '{ROW_TOL,  32'h0000_0000, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'h0001_0000, 1'b1, 25'h001_0000, 1'b1},
            '{ROW_ITEM, 32'h0000_0000, 1'b1, 25'h000_0000, 1'b0},
            '{ROW_ITEM, 32'h0004_0000, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 25'h0, 1'b0},
            '{ROW_TOL,  32'h0001_0000, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'hDEAD_BEEF, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'h5555_5555, 1'b0, 25'h0, 1'b0},
            '{ROW_ITEM, 32'hAAAA_AAAA, 1'b0, 25'h0, 1'b0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row_idx = 0; row_idx < ROW_COUNT; row_idx++) begin
            if (directed_rows[row_idx].kind == ROW_TOL) begin
                write_tolerance(directed_rows[row_idx].word);
            end else begin
                typed_result.root = directed_rows[row_idx].root;
                typed_result.cap_reached = directed_rows[row_idx].cap_reached;
                send_value(directed_rows[row_idx].word, directed_rows[row_idx].typed,
                           typed_result);
            end
        end

        // A zero tolerance runs every nonzero item to the iteration cap, so that phase stays short.
        phase_tols  = '{32'd1, 32'($urandom_range(2, 16)), 32'hFFFF_FFFF, $urandom,
                        32'd0, 32'($urandom_range(1, 32'h1_0000)), nsr_pkg::TOL_RESET};
        phase_items = '{80, 80, 80, 80, 15, 80, 80};
        typed_result = '0;
        for (phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
            write_tolerance(phase_tols[phase_idx]);
            steady = ($urandom_range(0, 3) == 0);
            for (item_idx = 0; item_idx < phase_items[phase_idx]; item_idx++) begin
                send_value(draw_value(), 1'b0, typed_result);
            end
        end

        wait_idle();
        steady = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_roots.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_roots.size()));
        end
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
